/* src/cdtic_pkg.sv */
// ----------------------------------------------------------------------------
// cdtic_pkg
// shared widths and limits of the cooldown task interval counter
// ----------------------------------------------------------------------------
package cdtic_pkg;

   localparam int LABEL_W    = 8;
   localparam int COOLDOWN_W = 10;
   localparam int TOTAL_W    = 26;
   // working width of the final evaluation, covers the default parameter values
   localparam int EVAL_W     = 34;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

/* src/cdtic_req_if.sv */
// ----------------------------------------------------------------------------
// cdtic_req_if
// request channel carrying one task label and the end-of-job mark
// ----------------------------------------------------------------------------
interface cdtic_req_if;
   import cdtic_pkg::*;

   logic               valid;
   logic               ready;
   logic [LABEL_W-1:0] task_label;
   logic               last_task;

   modport source (output valid, output task_label, output last_task, input ready);
   modport sink   (input valid, input task_label, input last_task, output ready);
endinterface

/* src/cdtic_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdtic_rsp_if
// response channel carrying the interval total of one job
// ----------------------------------------------------------------------------
interface cdtic_rsp_if;
   import cdtic_pkg::*;

   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] total_intervals;

   modport source (output valid, output total_intervals, input ready);
   modport sink   (input valid, input total_intervals, output ready);
endinterface

/* src/cooldown_task_interval_counter.sv */
// ----------------------------------------------------------------------------
// cooldown_task_interval_counter
// counts task labels per job and reports the minimum interval count under
// a cooldown between two runs of the same task
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                     | handshake
//  ---------+-----------+-----------------------------+----------------
//  req_ch   | in        | task_label[7:0], last_task  | valid / ready
//  rsp_ch   | out       | total_intervals[25:0]       | valid / ready
//  csr      | in        | csr_wr_data[9:0] (cooldown) | csr_wr_en
//
//  a request reads the histogram, then writes the count back
//  a request with last_task then runs one sweep over the histogram ram (one
//  entry a cycle, cleared as read), a drain step for the last read, one
//  multiply, and one final compare and saturate
//  after reset a clearing pass over every histogram entry runs before req_ch.ready
//  a result waits in the output register; a new job may stream in meanwhile,
//  only the final step waits for the output register to drain
//
//  result = max(task count, (max count - 1) * (cooldown + 1) + number of
//  labels at max count), zero for an empty job, saturated at the field top
// ----------------------------------------------------------------------------
module cooldown_task_interval_counter #(
   parameter int MAX_JOB_TASKS = 65536,
   parameter int LABEL_COUNT   = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cdtic_pkg::COOLDOWN_W-1:0] csr_wr_data,
   cdtic_req_if.sink                     req_ch,
   cdtic_rsp_if.source                   rsp_ch
);
   import cdtic_pkg::*;

   localparam int AW = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
   localparam int CW = $clog2(MAX_JOB_TASKS + 1);
   localparam int SW = CW + 9;
   localparam int KW = 9;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_UPD, ST_SWEEP, ST_DRAIN, ST_MULT, ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [COOLDOWN_W-1:0] cooldown_ff;
   logic [AW-1:0]         addr_ff;
   logic                  in_range_ff;
   logic                  last_ff;
   logic                  dvld_ff;
   logic [SW-1:0]         n_ff;
   logic [CW-1:0]         m_ff;
   logic [KW-1:0]         k_ff;
   logic [EVAL_W-1:0]     prod_ff;
   logic                  rsp_valid_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   // ram port signals
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] rd_data;

   logic              req_fire;
   logic              addr_end;
   logic              req_in_range;
   logic [EVAL_W-1:0] cand;
   logic [EVAL_W-1:0] best;
   logic [TOTAL_W-1:0] total_in;
   logic              out_free;
   logic              rsp_load;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign addr_end     = (addr_ff == AW'(LABEL_COUNT - 1));
   assign req_in_range = ({1'b0, req_ch.task_label} < 9'(LABEL_COUNT));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   // final step hands its total to the output register
   assign rsp_load     = (state_ff == ST_FINISH) && out_free;

   // histogram port usage per state
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = req_ch.task_label[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            rd_en = req_fire;
         end
         ST_UPD: begin
            // saturating increment of the addressed count
            wr_en   = in_range_ff;
            wr_data = (rd_data < CW'(MAX_JOB_TASKS)) ? rd_data + CW'(1) : rd_data;
         end
         ST_SWEEP: begin
            // read old value and clear the entry in the same cycle
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = addr_ff;
         end
         default: begin
         end
      endcase
   end

   cdtic_hist_ram #(
      .DEPTH (LABEL_COUNT),
      .WIDTH (CW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // final evaluation from the sweep statistics
   always_comb begin
      cand = prod_ff + EVAL_W'(k_ff);
      best = (cand > EVAL_W'(n_ff)) ? cand : EVAL_W'(n_ff);
      if (n_ff == '0) begin
         total_in = '0;
      end else if (best > EVAL_W'(TOTAL_MAX)) begin
         total_in = TOTAL_MAX;
      end else begin
         total_in = best[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cooldown_ff  <= '0;
         addr_ff      <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         m_ff         <= '0;
         k_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            cooldown_ff <= csr_wr_data;
         end
         // output register: load wins over drain in the same cycle
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_total_ff <= total_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (addr_end) begin
                  addr_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  addr_ff     <= req_ch.task_label[AW-1:0];
                  in_range_ff <= req_in_range;
                  last_ff     <= req_ch.last_task;
                  state_ff    <= ST_UPD;
               end
            end
            ST_UPD: begin
               if (last_ff) begin
                  addr_ff  <= '0;
                  dvld_ff  <= 1'b0;
                  n_ff     <= '0;
                  m_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_SWEEP;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SWEEP, ST_DRAIN: begin
               if (dvld_ff) begin
                  n_ff <= n_ff + SW'(rd_data);
                  if (rd_data > m_ff) begin
                     m_ff <= rd_data;
                     k_ff <= KW'(1);
                  end else if (rd_data == m_ff && rd_data != '0) begin
                     k_ff <= k_ff + KW'(1);
                  end
               end
               if (state_ff == ST_SWEEP) begin
                  dvld_ff <= 1'b1;
                  if (addr_end) begin
                     addr_ff  <= '0;
                     state_ff <= ST_DRAIN;
                  end else begin
                     addr_ff <= addr_ff + AW'(1);
                  end
               end else begin
                  dvld_ff  <= 1'b0;
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               // (max count - 1) * (cooldown + 1), zero when the job is empty
               prod_ff <= EVAL_W'(m_ff - CW'(m_ff != '0)) *
                          EVAL_W'({1'b0, cooldown_ff} + 11'd1);
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.total_intervals = rsp_total_ff;

`ifndef SYNTHESIS
   a_sweep_from_upd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && $past(state_ff) != ST_SWEEP) |-> $past(state_ff) == ST_UPD)
      else $error("sweep entered without an update step");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("histogram written while idle");

   a_max_when_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT && n_ff != '0) |-> (m_ff != '0 && k_ff != '0))
      else $error("nonzero task count without a maximum");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)
      else $error("finished job without a result");
`endif

endmodule

/* src/cdtic_hist_ram.sv */
// ----------------------------------------------------------------------------
// cdtic_hist_ram
// histogram storage, one write and one registered read port
// ----------------------------------------------------------------------------
module cdtic_hist_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
